>>> rtl/core/idi_pkg.sv
// Shared types, constants and table functions for the IR distance interpolator.
// Used by every module under rtl/core; depends on nothing else.

package idi_pkg;

    localparam int TABLE_SEGS       = 14;
    localparam int DEFAULT_SEGMENTS = 14;
    localparam int BASE_CM          = 10;
    localparam int STEP_CM          = 5;
    localparam int MIN_CM           = BASE_CM;
    localparam int MAX_CM           = BASE_CM + STEP_CM * TABLE_SEGS;

    localparam int CODE_W = 8;
    localparam int DIST_W = 7;
    localparam int VOLT_W = 9;
    localparam int DIFF_W = 7;
    localparam int SEG_W  = 4;
    localparam int FRAC_W = 3;
    localparam int NUM_W  = 9;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified transaction waiting for the interpolation stage.
    typedef struct packed {
        logic [SEG_W-1:0]  seg;
        logic [DIST_W-1:0] base_cm;
        logic [DIFF_W-1:0] diff;
    } idi_entry_t;

    // Table point voltages in centivolts, strictly falling.
    function automatic logic [VOLT_W-1:0] volt_cv(input logic [SEG_W-1:0] k);
        logic [VOLT_W-1:0] v;
        unique case (k)
            4'd0:    v = 9'd230;
            4'd1:    v = 9'd165;
            4'd2:    v = 9'd130;
            4'd3:    v = 9'd98;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd85;
            4'd6:    v = 9'd73;
            4'd7:    v = 9'd68;
            4'd8:    v = 9'd60;
            4'd9:    v = 9'd56;
            4'd10:   v = 9'd50;
            4'd11:   v = 9'd48;
            4'd12:   v = 9'd45;
            4'd13:   v = 9'd43;
            4'd14:   v = 9'd40;
            default: v = 9'd40;
        endcase
        return v;
    endfunction

    // Distance of table point k.
    function automatic logic [DIST_W-1:0] point_cm(input logic [SEG_W-1:0] k);
        logic [DIST_W-1:0] d;
        d = DIST_W'(BASE_CM) + DIST_W'(STEP_CM) * DIST_W'(k);
        return d;
    endfunction

endpackage

>>> rtl/core/idi_front.sv
// Front end: turns a converter code into a voltage and picks its table segment.
// Depends on idi_pkg.

module idi_front #(
    parameter int SEGMENTS = idi_pkg::DEFAULT_SEGMENTS
) (
    input  logic [idi_pkg::CODE_W-1:0] adc_code,
    output idi_pkg::idi_entry_t        entry
);
    import idi_pkg::*;

    localparam int USED = (SEGMENTS > TABLE_SEGS) ? TABLE_SEGS : SEGMENTS;

    logic [VOLT_W-1:0]     volt;
    logic [TABLE_SEGS-1:0] hit;

    // 0.02 V per code step, so the voltage in centivolts is twice the code.
    assign volt = {adc_code, 1'b0};

    always_comb begin
        for (int k = 0; k < TABLE_SEGS; k++) begin
            hit[k] = (k < USED) && (volt <= volt_cv(SEG_W'(k)))
                     && (volt >= volt_cv(SEG_W'(k + 1)));
        end
    end

    always_comb begin
        // Out-of-range voltages clamp to an end point with no fractional step.
        entry.seg  = '0;
        entry.diff = '0;
        if (volt > volt_cv('0)) begin
            entry.base_cm = point_cm('0);
        end else begin
            entry.base_cm = point_cm(SEG_W'(USED));
        end
        // Walk downward so the earliest matching segment wins on a shared point.
        for (int k = TABLE_SEGS - 1; k >= 0; k--) begin
            if (hit[k]) begin
                entry.seg     = SEG_W'(k);
                entry.base_cm = point_cm(SEG_W'(k));
                entry.diff    = DIFF_W'(volt_cv(SEG_W'(k)) - volt);
            end
        end
    end

endmodule

>>> rtl/core/idi_queue.sv
// Short queue that decouples the classifier from the interpolation stage.
// Depends on idi_pkg.

module idi_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  idi_pkg::idi_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output idi_pkg::idi_entry_t pop_entry
);
    import idi_pkg::*;

    idi_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/core/idi_back.sv
// Back end: interpolates inside the chosen segment and holds the result register.
// Depends on idi_pkg.

module idi_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  idi_pkg::idi_entry_t        in_entry,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [idi_pkg::DIST_W-1:0] m_distance_cm
);
    import idi_pkg::*;

    logic [DIFF_W-1:0] span;
    logic [NUM_W-1:0]  num;
    logic [FRAC_W-1:0] frac;
    logic [DIST_W-1:0] dist_cm;
    logic              valid_reg, valid_next;
    logic [DIST_W-1:0] dist_reg;

    assign span = DIFF_W'(volt_cv(in_entry.seg) - volt_cv(in_entry.seg + 1'b1));
    assign num  = NUM_W'(STEP_CM) * NUM_W'(in_entry.diff);

    // floor(5 * diff / span) is the number of multiples of span that num reaches.
    always_comb begin
        frac = '0;
        for (int j = 1; j <= STEP_CM; j++) begin
            if (num >= NUM_W'(j) * NUM_W'(span)) begin
                frac = frac + 1'b1;
            end
        end
    end

    assign dist_cm  = in_entry.base_cm + DIST_W'(frac);
    assign in_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            dist_reg <= dist_cm;
        end
    end

    assign m_valid       = valid_reg;
    assign m_distance_cm = dist_reg;

endmodule

>>> rtl/core/ir_distance_interpolator_unit.sv
// Top level of the IR distance interpolator: classifier, queue and interpolation stage.
// Depends on idi_pkg, idi_front, idi_queue and idi_back.

// Converts each 8-bit IR sensor sample into a distance of 10 to 80 cm by linear
// interpolation over a fixed 15-point voltage table, floored, clamped at both ends.
// The block takes one transaction per cycle while the queue has room. An accepted
// input is held in the two-entry queue behind the classifier and its result then in
// the output register. The queue lets the input keep flowing while a result
// waits to be taken; SEGMENTS limits how many table segments are used.

module ir_distance_interpolator_unit #(
    parameter int SEGMENTS = idi_pkg::DEFAULT_SEGMENTS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [idi_pkg::CODE_W-1:0] s_adc_code,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [idi_pkg::DIST_W-1:0] m_distance_cm
);
    import idi_pkg::*;

    idi_entry_t front_entry;
    idi_entry_t q_entry;
    logic       q_valid;
    logic       q_ready;

    idi_front #(
        .SEGMENTS (SEGMENTS)
    ) u_front (
        .adc_code (s_adc_code),
        .entry    (front_entry)
    );

    idi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_entry (front_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_entry  (q_entry)
    );

    idi_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_entry      (q_entry),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_distance_cm (m_distance_cm)
    );

    // A presented result always lies inside the table's distance range.
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_distance_cm >= DIST_W'(MIN_CM) && m_distance_cm <= DIST_W'(MAX_CM)))
        else $error("distance out of range");

    // The input only stalls when the queue holds transactions.
    a_stall_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_valid)
        else $error("input stalled with empty queue");

    // A queued transaction moves on whenever the output register is free.
    a_queue_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !m_valid) |=> m_valid)
        else $error("queue did not drain into free output register");

endmodule

>>> tb/tb_ir_distance_interpolator_unit.sv
// Self-checking testbench for ir_distance_interpolator_unit: directed and random sensor
// codes, bursty input, a patterned output stall and a long output hold-off.
// Depends on idi_pkg and the RTL under rtl/core.

module tb_ir_distance_interpolator_unit;

    import idi_pkg::*;

    localparam int SEGMENTS      = DEFAULT_SEGMENTS;
    localparam int HOLD_CYCLES   = 64;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int FULL_RATE_ITEMS = 200;
    localparam int HOLD_ITEMS    = 60;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CODE_W-1:0]   s_adc_code;
    logic                m_valid;
    logic                m_ready;
    logic [DIST_W-1:0]   m_distance_cm;

    // Table point voltages in centivolts, strictly falling with distance.
    bit [VOLT_W-1:0] point_cv [0:TABLE_SEGS] = '{
        9'd230, 9'd165, 9'd130, 9'd98, 9'd90, 9'd85, 9'd73, 9'd68,
        9'd60, 9'd56, 9'd50, 9'd48, 9'd45, 9'd43, 9'd40
    };

    logic [DIST_W-1:0] pending_cm [$];
    logic [DIST_W-1:0] oldest_cm;
    int unsigned       mismatch_count = 0;
    int unsigned       hold_req = 0;
    int unsigned       hold_done = 0;

    ir_distance_interpolator_unit #(
        .SEGMENTS(SEGMENTS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_adc_code   (s_adc_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_distance_cm(m_distance_cm)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // The code is doubled into centivolts and placed in the first segment that
    // holds it; the slope inside a segment is 5 cm over the segment's voltage span.
    function automatic logic [DIST_W-1:0] predict_distance_cm(input logic [CODE_W-1:0] code);
        int unsigned volt;
        int unsigned segs;
        int unsigned hi;
        int unsigned lo;
        volt = 2 * code;
        segs = (SEGMENTS > TABLE_SEGS) ? TABLE_SEGS : SEGMENTS;
        for (int unsigned k = 0; k < segs; k++) begin
            hi = point_cv[k];
            lo = point_cv[k + 1];
            if (volt <= hi && volt >= lo) begin
                return DIST_W'(BASE_CM + STEP_CM * k + (STEP_CM * (hi - volt)) / (hi - lo));
            end
        end
        if (volt > point_cv[0]) begin
            return DIST_W'(BASE_CM);
        end
        return DIST_W'(BASE_CM + STEP_CM * segs);
    endfunction

    // Most codes fall inside the table's voltage range, where the segments are.
    function automatic logic [CODE_W-1:0] random_code();
        if ($urandom_range(0, 9) < 6) begin
            return CODE_W'($urandom_range(18, 118));
        end
        return CODE_W'($urandom_range(0, 255));
    endfunction

    // Offers one code and returns at the edge where it is accepted; valid stays
    // high so the next transaction can follow without a gap.
    task automatic send_code(input logic [CODE_W-1:0] code);
        s_valid    <= 1'b1;
        s_adc_code <= code;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_cm.push_back(predict_distance_cm(code));
    endtask

    task automatic pause_input(input int unsigned cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic test_table_points();
        logic [CODE_W-1:0] codes [$];
        codes = '{8'd0, 8'd1, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd28,
                  8'd30, 8'd34, 8'd36, 8'd42, 8'd45, 8'd49, 8'd50, 8'd65, 8'd82,
                  8'd83, 8'd114, 8'd115, 8'd116, 8'd170, 8'd255};
        foreach (codes[i]) begin
            send_code(codes[i]);
            if ($urandom_range(0, 3) == 0) begin
                pause_input($urandom_range(1, 3));
            end
        end
    endtask

    task automatic test_random_bursts();
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                send_code(random_code());
                sent++;
            end
            if ($urandom_range(0, 4) != 0) begin
                pause_input($urandom_range(1, 8));
            end
        end
    endtask

    task automatic test_full_rate();
        repeat (FULL_RATE_ITEMS) send_code(random_code());
    endtask

    // The output is held off while codes keep coming, so the queue fills and
    // the input has to stall until the output is released.
    task automatic test_output_hold();
        hold_req++;
        repeat (HOLD_ITEMS) send_code(random_code());
    endtask

    // Output stall pattern: stretches of always ready, random, sparse and
    // periodic acceptance, plus one long hold-off on request.
    initial begin
        int unsigned stretch_left;
        int unsigned mode;
        int unsigned phase;
        stretch_left = 0;
        mode = 0;
        phase = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                hold_done++;
            end else begin
                if (stretch_left == 0) begin
                    mode = $urandom_range(0, 3);
                    stretch_left = $urandom_range(4, 40);
                end
                stretch_left--;
                phase++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (phase % 3 != 2);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_cm.size() == 0) begin
                $error("distance_cm: expected none, actual %0d", m_distance_cm);
                mismatch_count++;
            end else begin
                oldest_cm = pending_cm.pop_front();
                if (m_distance_cm !== oldest_cm) begin
                    $error("distance_cm: expected %0d, actual %0d", oldest_cm, m_distance_cm);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_adc_code <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_table_points();
        test_random_bursts();
        test_full_rate();
        test_output_hold();
        s_valid <= 1'b0;

        while (pending_cm.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/idi_pkg.sv
rtl/core/idi_front.sv
rtl/core/idi_queue.sv
rtl/core/idi_back.sv
rtl/core/ir_distance_interpolator_unit.sv
tb/tb_ir_distance_interpolator_unit.sv
